@@ src/lrut_pkg.sv @@
// ----------------------------------------------------------------------------
// lrut_pkg
// Shared types and constants of the LRU cache with time-to-live expiry.
// ----------------------------------------------------------------------------
package lrut_pkg;

  localparam int unsigned ENTRIES_DEF   = 16;
  localparam int unsigned LIFE_BITS_DEF = 16;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned TTL_W   = 16;
  localparam int unsigned EXP_W   = 5;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [MODE_W-1:0] MODE_GET  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TTL      = 1'b1;

  localparam logic [CAP_W-1:0] CAPACITY_RST = 5'd16;
  localparam logic [TTL_W-1:0] TTL_RST      = 16'd60;
  localparam logic [EXP_W-1:0] EXP_MAX      = 5'd31;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PROMOTE,
    CELL_INSERT,
    CELL_REPLACE,
    CELL_AGE,
    CELL_COMPACT
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

@@ src/lrut_if.sv @@
// ----------------------------------------------------------------------------
// lrut_in_if / lrut_out_if
// Valid/ready channels carrying request and result words of the cache.
// ----------------------------------------------------------------------------
interface lrut_in_if;
  logic                              valid;
  logic                              ready;
  logic [lrut_pkg::MODE_W-1:0]       mode;
  logic signed [lrut_pkg::KEY_W-1:0] key;
  logic signed [lrut_pkg::DATA_W-1:0] value;

  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

interface lrut_out_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic signed [lrut_pkg::DATA_W-1:0] read_value;
  logic                               evicted;
  logic signed [lrut_pkg::KEY_W-1:0]  evicted_key;
  logic [lrut_pkg::EXP_W-1:0]         expired_count;

  modport source (output valid, hit, read_value, evicted, evicted_key, expired_count,
                  input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, expired_count,
                  output ready);
endinterface

@@ src/lrut_cell.sv @@
// ----------------------------------------------------------------------------
// lrut_cell
// One cache entry of the recency-ordered chain; shifts from its neighbors.
// ----------------------------------------------------------------------------
module lrut_cell #(
  parameter int unsigned LIFE_BITS = lrut_pkg::LIFE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lrut_pkg::cell_ctrl_t        ctrl_i,
  input  logic                        prev_valid_i,
  input  logic [lrut_pkg::KEY_W-1:0]  prev_key_i,
  input  logic [lrut_pkg::DATA_W-1:0] prev_data_i,
  input  logic [LIFE_BITS-1:0]        prev_life_i,
  input  logic                        prev_dying_i,
  input  logic                        next_valid_i,
  input  logic [lrut_pkg::KEY_W-1:0]  next_key_i,
  input  logic [lrut_pkg::DATA_W-1:0] next_data_i,
  input  logic [LIFE_BITS-1:0]        next_life_i,
  input  logic                        next_dying_i,
  input  logic                        sfx_i,
  output logic                        sfx_o,
  input  logic                        dpfx_i,
  output logic                        dpfx_o,
  input  logic [lrut_pkg::DATA_W-1:0] dchain_i,
  output logic [lrut_pkg::DATA_W-1:0] dchain_o,
  input  logic [lrut_pkg::KEY_W-1:0]  kchain_i,
  output logic [lrut_pkg::KEY_W-1:0]  kchain_o,
  output logic                        valid_o,
  output logic [lrut_pkg::KEY_W-1:0]  key_o,
  output logic [lrut_pkg::DATA_W-1:0] data_o,
  output logic [LIFE_BITS-1:0]        life_o,
  output logic                        dying_o
);
  import lrut_pkg::*;

  logic                valid_q, valid_d;
  logic                dying_q, dying_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [DATA_W-1:0]   data_q, data_d;
  logic [LIFE_BITS-1:0] life_q, life_d;
  logic                match;
  logic                take_prev;
  logic                take_next;

  assign match    = valid_q && (key_q == ctrl_i.key);
  assign sfx_o    = sfx_i | match;
  assign dpfx_o   = dpfx_i | dying_q;
  assign dchain_o = dchain_i | (match ? data_q : '0);
  assign kchain_o = kchain_i | ((valid_q && !next_valid_i) ? key_q : '0);

  always_comb begin
    take_prev = 1'b0;
    take_next = 1'b0;
    valid_d   = valid_q;
    dying_d   = dying_q;
    key_d     = key_q;
    data_d    = data_q;
    life_d    = life_q;
    case (ctrl_i.op)
      CELL_PROMOTE: take_prev = sfx_o;
      CELL_INSERT:  take_prev = prev_valid_i;
      CELL_REPLACE: take_prev = valid_q;
      CELL_COMPACT: take_next = dpfx_o;
      CELL_AGE: begin
        if (valid_q) begin
          life_d  = life_q - LIFE_BITS'(1);
          dying_d = (life_q == LIFE_BITS'(1));
        end
      end
      default: ;
    endcase
    if (take_prev) begin
      valid_d = prev_valid_i;
      dying_d = prev_dying_i;
      key_d   = prev_key_i;
      data_d  = prev_data_i;
      life_d  = prev_life_i;
    end else if (take_next) begin
      valid_d = next_valid_i;
      dying_d = next_dying_i;
      key_d   = next_key_i;
      data_d  = next_data_i;
      life_d  = next_life_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dying_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      dying_q <= dying_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    data_q <= data_d;
    life_q <= life_d;
  end

  assign valid_o = valid_q;
  assign dying_o = dying_q;
  assign key_o   = key_q;
  assign data_o  = data_q;
  assign life_o  = life_q;

endmodule

@@ src/lru_cache_with_ttl_expiry_top.sv @@
// ----------------------------------------------------------------------------
// lru_cache_with_ttl_expiry_top
// Fully associative key/value cache with LRU replacement and tick-based expiry.
// ----------------------------------------------------------------------------
// Requests enter on in_i as words of mode (get, put or tick), key and value.
// Every request yields exactly one result word on out_o: hit, read value,
// evicted flag and key, and the number of entries expired by a tick.
// Entries sit in a chain of cells ordered by recency, the most recent at
// cell zero, so a hit or an insert is one shift of a prefix of the chain.
// For a get or put, the key is compared in every cell in the cycle it is
// accepted, and the chain shifts in the apply state. A tick ages every
// entry in the apply state, then the chain closes one gap per cycle until
// no expired entry is left. The configuration port writes capacity and
// ttl_ticks and may be used only while no request is in flight.
// Reset empties the cache at once and restores capacity 16 and ttl 60.
// A result waits in an output register while the receiver stalls; the next
// request is still accepted, but only a get or put waits to update the chain.
// ----------------------------------------------------------------------------
module lru_cache_with_ttl_expiry_top #(
  parameter int unsigned ENTRIES   = lrut_pkg::ENTRIES_DEF,
  parameter int unsigned LIFE_BITS = lrut_pkg::LIFE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lrut_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lrut_pkg::CFG_W-1:0]      cfg_data_i,
  lrut_in_if.sink                         in_i,
  lrut_out_if.source                      out_o
);
  import lrut_pkg::*;

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CAPX_W = ($clog2(ENTRIES + 1) > CAP_W) ? $clog2(ENTRIES + 1)
                                                                : CAP_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_APPLY = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CAP_W-1:0]  capacity_q;
  logic [TTL_W-1:0]  ttl_q;

  logic [MODE_W-1:0] mode_q;
  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] value_q;
  logic              hit_q;
  logic [DATA_W-1:0] hdata_q;
  logic [KEY_W-1:0]  lkey_q;
  logic              full_q;
  logic [EXP_W-1:0]  cnt_q, cnt_d;

  logic              out_valid_q;
  logic              res_hit_q, res_ev_q;
  logic [DATA_W-1:0] res_rd_q;
  logic [KEY_W-1:0]  res_evk_q;
  logic [EXP_W-1:0]  res_exp_q;

  logic              emit, emit_ok, accept;
  logic              res_hit, res_ev;
  logic [DATA_W-1:0] res_rd;
  logic [KEY_W-1:0]  res_evk;
  logic [EXP_W-1:0]  res_exp;
  cell_op_e          op;
  cell_ctrl_t        ctrl;

  logic [CAPX_W-1:0] cap_x, cap_eff, cap_m1;
  logic              full;
  logic [32:0]       ttl_ext, max_ext;
  logic [LIFE_BITS-1:0] life_load;
  logic [DATA_W-1:0] new_data;

  logic [ENTRIES:0]  sfx_w, dpfx_w;
  logic [DATA_W-1:0] dch_w [ENTRIES+1];
  logic [KEY_W-1:0]  kch_w [ENTRIES+1];
  logic [ENTRIES-1:0] ent_valid, ent_dying;
  logic [KEY_W-1:0]  ent_key  [ENTRIES];
  logic [DATA_W-1:0] ent_data [ENTRIES];
  logic [LIFE_BITS-1:0] ent_life [ENTRIES];
  logic [ENTRIES:0]  valid_inc;

  assign accept  = in_i.valid && in_i.ready;
  assign emit_ok = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    cap_x = CAPX_W'(capacity_q);
    if (cap_x == '0) begin
      cap_eff = CAPX_W'(1);
    end else if (cap_x > CAPX_W'(ENTRIES)) begin
      cap_eff = CAPX_W'(ENTRIES);
    end else begin
      cap_eff = cap_x;
    end
    cap_m1 = cap_eff - CAPX_W'(1);
    full   = ent_valid[cap_m1[IDX_W-1:0]];
  end

  always_comb begin
    ttl_ext = 33'(ttl_q);
    max_ext = (33'd1 << LIFE_BITS) - 33'd1;
    if (ttl_q == '0) begin
      life_load = LIFE_BITS'(1);
    end else if (ttl_ext > max_ext) begin
      life_load = max_ext[LIFE_BITS-1:0];
    end else begin
      life_load = ttl_ext[LIFE_BITS-1:0];
    end
  end

  assign new_data = (mode_q == MODE_GET) ? hdata_q : value_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    op      = CELL_HOLD;
    emit    = 1'b0;
    res_hit = 1'b0;
    res_rd  = '0;
    res_ev  = 1'b0;
    res_evk = '0;
    res_exp = '0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (mode_q == MODE_TICK) begin
          op      = CELL_AGE;
          cnt_d   = '0;
          state_d = S_DRAIN;
        end else if (emit_ok) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (mode_q == MODE_GET) begin
            res_hit = hit_q;
            if (hit_q) begin
              op     = CELL_PROMOTE;
              res_rd = hdata_q;
            end
          end else if (mode_q == MODE_PUT) begin
            if (hit_q) begin
              res_hit = 1'b1;
              op      = CELL_PROMOTE;
            end else if (full_q) begin
              op      = CELL_REPLACE;
              res_ev  = 1'b1;
              res_evk = lkey_q;
            end else begin
              op = CELL_INSERT;
            end
          end
        end
      end
      S_DRAIN: begin
        if (dpfx_w[ENTRIES]) begin
          op = CELL_COMPACT;
          if (cnt_q != EXP_MAX) begin
            cnt_d = cnt_q + EXP_W'(1);
          end
        end else if (emit_ok) begin
          emit    = 1'b1;
          res_exp = cnt_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ctrl.op  = op;
  assign ctrl.key = (state_q == S_IDLE) ? KEY_W'(in_i.key) : key_q;

  assign sfx_w[ENTRIES] = 1'b0;
  assign dpfx_w[0]      = 1'b0;
  assign dch_w[ENTRIES] = '0;
  assign kch_w[ENTRIES] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic                 p_valid, p_dying, n_valid, n_dying;
    logic [KEY_W-1:0]     p_key, n_key;
    logic [DATA_W-1:0]    p_data, n_data;
    logic [LIFE_BITS-1:0] p_life, n_life;

    if (g == 0) begin : g_head
      assign p_valid = 1'b1;
      assign p_dying = 1'b0;
      assign p_key   = key_q;
      assign p_data  = new_data;
      assign p_life  = life_load;
    end else begin : g_body
      assign p_valid = ent_valid[g-1];
      assign p_dying = ent_dying[g-1];
      assign p_key   = ent_key[g-1];
      assign p_data  = ent_data[g-1];
      assign p_life  = ent_life[g-1];
    end

    if (g == ENTRIES - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_dying = 1'b0;
      assign n_key   = '0;
      assign n_data  = '0;
      assign n_life  = '0;
    end else begin : g_next
      assign n_valid = ent_valid[g+1];
      assign n_dying = ent_dying[g+1];
      assign n_key   = ent_key[g+1];
      assign n_data  = ent_data[g+1];
      assign n_life  = ent_life[g+1];
    end

    lrut_cell #(
      .LIFE_BITS (LIFE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (p_valid),
      .prev_key_i   (p_key),
      .prev_data_i  (p_data),
      .prev_life_i  (p_life),
      .prev_dying_i (p_dying),
      .next_valid_i (n_valid),
      .next_key_i   (n_key),
      .next_data_i  (n_data),
      .next_life_i  (n_life),
      .next_dying_i (n_dying),
      .sfx_i        (sfx_w[g+1]),
      .sfx_o        (sfx_w[g]),
      .dpfx_i       (dpfx_w[g]),
      .dpfx_o       (dpfx_w[g+1]),
      .dchain_i     (dch_w[g+1]),
      .dchain_o     (dch_w[g]),
      .kchain_i     (kch_w[g+1]),
      .kchain_o     (kch_w[g]),
      .valid_o      (ent_valid[g]),
      .key_o        (ent_key[g]),
      .data_o       (ent_data[g]),
      .life_o       (ent_life[g]),
      .dying_o      (ent_dying[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      capacity_q  <= CAPACITY_RST;
      ttl_q       <= TTL_RST;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CAPACITY: capacity_q <= cfg_data_i[CAP_W-1:0];
          REG_TTL:      ttl_q      <= cfg_data_i[TTL_W-1:0];
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= in_i.mode;
      key_q   <= KEY_W'(in_i.key);
      value_q <= DATA_W'(in_i.value);
      hit_q   <= sfx_w[0];
      hdata_q <= dch_w[0];
      lkey_q  <= kch_w[0];
      full_q  <= full;
    end
    if (emit) begin
      res_hit_q <= res_hit;
      res_rd_q  <= res_rd;
      res_ev_q  <= res_ev;
      res_evk_q <= res_evk;
      res_exp_q <= res_exp;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.hit           = res_hit_q;
  assign out_o.read_value    = res_rd_q;
  assign out_o.evicted       = res_ev_q;
  assign out_o.evicted_key   = res_evk_q;
  assign out_o.expired_count = res_exp_q;

  assign valid_inc = {1'b0, ent_valid} + (ENTRIES + 1)'(1);

  a_chain_compact : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_inc[ENTRIES-1:0] & ent_valid) == '0)
    else $error("valid entries are not packed toward the head of the chain");

  a_dying_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ent_dying != '0) |-> (state_q == S_DRAIN))
    else $error("expiring entries remain outside the drain phase");

  a_apply_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY && mode_q != MODE_TICK && emit_ok) |=> out_valid_q)
    else $error("a lookup finished without presenting its result");

  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_hit_q && res_ev_q))
    else $error("a result reports both a hit and an eviction");

endmodule
